// ----- hw/rtl/fsplm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fsplm_pkg;

	localparam int NUM_SECTORS      = 16;
	localparam int PAGES_PER_SECTOR = 16;
	localparam int PAGE_BYTES       = 256;

	localparam int OP_W   = 3;
	localparam int SEC_W  = 4;
	localparam int PAGE_W = 4;
	localparam int ADDR_W = 16;
	localparam int CNT_W  = 5;
	// current page counts one past the last page
	localparam int CPAGE_W = $clog2(PAGES_PER_SECTOR + 1);
	localparam int SCNT_W  = $clog2(NUM_SECTORS + 1);
	localparam int PCNT_W  = $clog2(PAGES_PER_SECTOR + 1);

	localparam logic [OP_W-1:0] OP_SAVE_HDR  = 3'd0;
	localparam logic [OP_W-1:0] OP_SAVE_DATA = 3'd1;
	localparam logic [OP_W-1:0] OP_LOAD_HDR  = 3'd2;
	localparam logic [OP_W-1:0] OP_LOAD_DATA = 3'd3;
	localparam logic [OP_W-1:0] OP_QUERY     = 3'd4;

	typedef struct packed {
		logic accept;
		logic find;
		logic exec;
		logic qry;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} sts_t;

	typedef logic [PAGES_PER_SECTOR-1:0] row_t;

endpackage

`default_nettype wire

// ----- hw/rtl/flash_sector_page_log_manager.sv -----
// Flash sector/page log manager.
// Input channel (in_valid/in_ready): one request per transaction, op selects
// save header, save data, load header, load data or query; query_sector picks
// the sector whose clean pages are counted. Output channel (out_valid/out_ready):
// one result per request, carrying at most one flash command (program, read or
// erase) with its sector, page and byte address, plus the free-sector count and
// the clean-page count of query_sector, both taken after the request.
// A request passes through the find, exec, qry and cnt states. One request is in
// flight at a time, and a new one is taken only after cnt has loaded the last
// result; find reads the target row through the single read port of the mark
// RAM, exec searches and updates it, qry reads the queried row, and cnt loads
// the result, waiting while the output register is still busy.
// Reset clears every page mark to clean, drops the current sector and sets the
// current page to 0; the RAM needs no clearing pass since per-row valid bits
// make unwritten rows read clean.
// A stalled receiver holds the result in the output register; the next request
// can already be accepted, and its result waits until the register is free.
`timescale 1ns / 1ps
`default_nettype none

module flash_sector_page_log_manager (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [fsplm_pkg::OP_W-1:0]     op,
	input  wire logic [fsplm_pkg::SEC_W-1:0]    query_sector,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic                                status,
	output logic                                do_write,
	output logic                                do_read,
	output logic                                do_erase,
	output logic      [fsplm_pkg::SEC_W-1:0]    sel_sector,
	output logic      [fsplm_pkg::PAGE_W-1:0]   sel_page,
	output logic      [fsplm_pkg::ADDR_W-1:0]   flash_addr,
	output logic      [fsplm_pkg::CNT_W-1:0]    free_sectors,
	output logic      [fsplm_pkg::CNT_W-1:0]    free_pages
);

	import fsplm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	fsplm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd     (cmd),
		.sts     (sts)
	);

	fsplm_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.op          (op),
		.query_sector(query_sector),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.do_write    (do_write),
		.do_read     (do_read),
		.do_erase    (do_erase),
		.sel_sector  (sel_sector),
		.sel_page    (sel_page),
		.flash_addr  (flash_addr),
		.free_sectors(free_sectors),
		.free_pages  (free_pages)
	);

	// busy for the rest of the transaction after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while a transaction was in flight");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> out_valid)
		else $error("result register loaded without raising out_valid");

	a_one_command: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0({do_write, do_read, do_erase}))
		else $error("more than one flash command in one result");

	a_erase_fails: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && do_erase |-> status && (sel_page == '0))
		else $error("erase reported with success or nonzero page");

endmodule

`default_nettype wire

// ----- hw/rtl/fsplm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fsplm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/fsplm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fsplm_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output fsplm_pkg::cmd_t    cmd,
	input  wire fsplm_pkg::sts_t sts
);

	import fsplm_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIND,
		ST_EXEC,
		ST_QRY,
		ST_CNT
	} state_t;

	state_t state_q;

	assign in_ready   = (state_q == ST_IDLE);
	assign cmd.accept = in_valid && (state_q == ST_IDLE);
	assign cmd.find   = (state_q == ST_FIND);
	assign cmd.exec   = (state_q == ST_EXEC);
	assign cmd.qry    = (state_q == ST_QRY);
	assign cmd.load   = (state_q == ST_CNT) && !sts.out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_FIND;
					end
				end
				ST_FIND: state_q <= ST_EXEC;
				ST_EXEC: state_q <= ST_QRY;
				ST_QRY:  state_q <= ST_CNT;
				ST_CNT: begin
					// hold until the output register frees up
					if (!sts.out_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/fsplm_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fsplm_dp (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire fsplm_pkg::cmd_t                cmd,
	output fsplm_pkg::sts_t                     sts,
	input  wire logic [fsplm_pkg::OP_W-1:0]     op,
	input  wire logic [fsplm_pkg::SEC_W-1:0]    query_sector,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic                                status,
	output logic                                do_write,
	output logic                                do_read,
	output logic                                do_erase,
	output logic      [fsplm_pkg::SEC_W-1:0]    sel_sector,
	output logic      [fsplm_pkg::PAGE_W-1:0]   sel_page,
	output logic      [fsplm_pkg::ADDR_W-1:0]   flash_addr,
	output logic      [fsplm_pkg::CNT_W-1:0]    free_sectors,
	output logic      [fsplm_pkg::CNT_W-1:0]    free_pages
);

	import fsplm_pkg::*;

	// transaction fields
	logic [OP_W-1:0]  op_q;
	logic [SEC_W-1:0] qs_q;

	// log state
	logic [SEC_W-1:0]       cur_sector_q;
	logic                   sector_valid_q;
	logic [CPAGE_W-1:0]     cur_page_q;
	logic                   page_valid_q;
	logic [NUM_SECTORS-1:0] first_q;    // page 0 mark of every sector
	logic [NUM_SECTORS-1:0] row_vld_q;  // row written since reset

	logic [SEC_W-1:0] tgt_s1;
	logic             tgt_ok_s1;
	logic             rvld_s1;

	logic             status_s2;
	logic             wr_s2;
	logic             rd_s2;
	logic             er_s2;
	logic [SEC_W-1:0] sel_sector_s2;
	logic [PAGE_W-1:0] sel_page_s2;
	logic [ADDR_W-1:0] addr_s2;
	logic [SCNT_W-1:0] fsec_s2;

	logic             out_valid_q;

	// mark RAM
	logic             ram_we;
	logic             ram_re;
	logic [SEC_W-1:0] ram_raddr;
	row_t             ram_rdata;
	row_t             row;

	// search results
	logic [SEC_W-1:0]  fc_idx;
	logic              fc_ok;
	logic [SEC_W-1:0]  fw_idx;
	logic              fw_ok;
	logic [SEC_W-1:0]  tgt;
	logic              tgt_ok;
	logic [PAGE_W-1:0] fp_idx;
	logic              fp_ok;

	// exec next values
	logic [SEC_W-1:0]   cur_sector_d;
	logic               sector_valid_d;
	logic [CPAGE_W-1:0] cur_page_d;
	logic               page_valid_d;
	row_t               new_row;
	logic               row_we;
	logic               st_d;
	logic               wr_d;
	logic               rd_d;
	logic               er_d;
	logic [SEC_W-1:0]   cs_d;
	logic [PAGE_W-1:0]  cp_d;
	logic [31:0]        addr_full;

	logic [SCNT_W-1:0] fsec_cnt;
	logic [PCNT_W-1:0] fpg_cnt;
	logic [CNT_W-1:0]  fpg_out;

	assign sts.out_busy = out_valid_q && !out_ready;
	assign row          = rvld_s1 ? ram_rdata : '0;

	fsplm_ram #(
		.WIDTH(PAGES_PER_SECTOR),
		.DEPTH(NUM_SECTORS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(tgt_s1),
		.wdata(new_row),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign ram_re    = cmd.find || cmd.qry;
	assign ram_raddr = cmd.find ? tgt : qs_q;
	assign ram_we    = cmd.exec && row_we;

	// lowest sector with clean / written first page
	always_comb begin
		fc_idx = '0;
		fc_ok  = 1'b0;
		fw_idx = '0;
		fw_ok  = 1'b0;
		for (int i = NUM_SECTORS - 1; i >= 0; i--) begin
			if (!first_q[i]) begin
				fc_idx = SEC_W'(i);
				fc_ok  = 1'b1;
			end else begin
				fw_idx = SEC_W'(i);
				fw_ok  = 1'b1;
			end
		end
	end

	always_comb begin
		unique case (op_q)
			OP_SAVE_HDR: begin
				tgt    = fc_idx;
				tgt_ok = fc_ok;
			end
			OP_LOAD_HDR: begin
				tgt    = fw_idx;
				tgt_ok = fw_ok;
			end
			default: begin
				tgt    = cur_sector_q;
				tgt_ok = sector_valid_q;
			end
		endcase
	end

	// lowest clean page of the fetched row
	always_comb begin
		fp_idx = '0;
		fp_ok  = 1'b0;
		for (int i = PAGES_PER_SECTOR - 1; i >= 0; i--) begin
			if (!row[i]) begin
				fp_idx = PAGE_W'(i);
				fp_ok  = 1'b1;
			end
		end
	end

	always_comb begin
		cur_sector_d   = cur_sector_q;
		sector_valid_d = sector_valid_q;
		cur_page_d     = cur_page_q;
		page_valid_d   = page_valid_q;
		new_row        = row;
		row_we         = 1'b0;
		st_d           = 1'b1;
		wr_d           = 1'b0;
		rd_d           = 1'b0;
		er_d           = 1'b0;
		cs_d           = '0;
		cp_d           = '0;
		unique case (op_q)
			OP_SAVE_HDR: begin
				if (tgt_ok_s1) begin
					cur_sector_d   = tgt_s1;
					sector_valid_d = 1'b1;
					cur_page_d     = '0;
					page_valid_d   = 1'b1;
					new_row[0]     = 1'b1;
					row_we         = 1'b1;
					wr_d           = 1'b1;
					cs_d           = tgt_s1;
					st_d           = 1'b0;
				end else begin
					sector_valid_d = 1'b0;
				end
			end
			OP_SAVE_DATA: begin
				if (sector_valid_q) begin
					if (fp_ok) begin
						cur_page_d      = CPAGE_W'(fp_idx);
						page_valid_d    = 1'b1;
						new_row[fp_idx] = 1'b1;
						row_we          = 1'b1;
						wr_d            = 1'b1;
						cs_d            = cur_sector_q;
						cp_d            = fp_idx;
						st_d            = 1'b0;
					end else begin
						page_valid_d = 1'b0;
					end
				end
			end
			OP_LOAD_HDR: begin
				cur_page_d   = '0;
				page_valid_d = 1'b1;
				if (tgt_ok_s1) begin
					cur_sector_d   = tgt_s1;
					sector_valid_d = 1'b1;
					cur_page_d     = CPAGE_W'(1);
					rd_d           = 1'b1;
					cs_d           = tgt_s1;
					st_d           = 1'b0;
				end else begin
					sector_valid_d = 1'b0;
				end
			end
			OP_LOAD_DATA: begin
				if (sector_valid_q) begin
					if (page_valid_q && (int'(cur_page_q) < PAGES_PER_SECTOR) &&
					    row[cur_page_q[PAGE_W-1:0]]) begin
						rd_d       = 1'b1;
						cs_d       = cur_sector_q;
						cp_d       = cur_page_q[PAGE_W-1:0];
						cur_page_d = cur_page_q + CPAGE_W'(1);
						st_d       = 1'b0;
					end else begin
						// erase the sector: every page goes clean
						new_row = '0;
						row_we  = 1'b1;
						er_d    = 1'b1;
						cs_d    = cur_sector_q;
					end
				end
			end
			OP_QUERY: st_d = 1'b0;
			default: st_d = 1'b1;
		endcase
	end

	assign addr_full = (32'(cs_d) * 32'(PAGES_PER_SECTOR) + 32'(cp_d)) * 32'(PAGE_BYTES);

	always_comb begin
		fsec_cnt = '0;
		for (int i = 0; i < NUM_SECTORS; i++) begin
			fsec_cnt = fsec_cnt + SCNT_W'(!first_q[i]);
		end
	end

	always_comb begin
		fpg_cnt = '0;
		for (int i = 0; i < PAGES_PER_SECTOR; i++) begin
			fpg_cnt = fpg_cnt + PCNT_W'(!row[i]);
		end
		fpg_out = (int'(qs_q) < NUM_SECTORS) ? CNT_W'(fpg_cnt) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_sector_q   <= '0;
			sector_valid_q <= 1'b0;
			cur_page_q     <= '0;
			page_valid_q   <= 1'b1;
			first_q        <= '0;
			row_vld_q      <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cmd.exec) begin
				cur_sector_q   <= cur_sector_d;
				sector_valid_q <= sector_valid_d;
				cur_page_q     <= cur_page_d;
				page_valid_q   <= page_valid_d;
				if (row_we) begin
					row_vld_q[tgt_s1] <= 1'b1;
					first_q[tgt_s1]   <= new_row[0];
				end
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q <= op;
			qs_q <= query_sector;
		end
		if (cmd.find) begin
			tgt_s1    <= tgt;
			tgt_ok_s1 <= tgt_ok;
			rvld_s1   <= row_vld_q[tgt];
		end
		if (cmd.exec) begin
			status_s2     <= st_d;
			wr_s2         <= wr_d;
			rd_s2         <= rd_d;
			er_s2         <= er_d;
			sel_sector_s2 <= cs_d;
			sel_page_s2   <= cp_d;
			addr_s2       <= addr_full[ADDR_W-1:0];
		end
		if (cmd.qry) begin
			rvld_s1 <= row_vld_q[qs_q];
			fsec_s2 <= fsec_cnt;
		end
		if (cmd.load) begin
			status       <= status_s2;
			do_write     <= wr_s2;
			do_read      <= rd_s2;
			do_erase     <= er_s2;
			sel_sector   <= sel_sector_s2;
			sel_page     <= sel_page_s2;
			flash_addr   <= addr_s2;
			free_sectors <= CNT_W'(fsec_s2);
			free_pages   <= fpg_out;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire
